>>> hw/rtl/kip_pkg.sv
// ----------------------------------------------------------------------------
// kip_pkg
// Shared types, constants and the microcode program of the keyed index
// permutation block.
// ----------------------------------------------------------------------------
`default_nettype none

package kip_pkg;

    localparam int DOM_W   = 62;          // widest index range in bits
    localparam int W_WORD  = 64;          // datapath word
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 31;
    localparam int CFG_W   = DOM_W;       // configuration data port
    localparam int IDX_W   = 3;           // configuration register index
    localparam int SAMP_W  = 31;
    localparam int HALF_W  = W_WORD / 2;
    localparam int PC_W    = 6;
    localparam int SH_W    = 6;

    localparam logic [W_WORD-1:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [W_WORD-1:0] SM_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam logic [W_WORD-1:0] SM_MUL_B   = 64'h94D049BB133111EB;
    localparam logic [W_WORD-1:0] PERM_MUL_A = 64'hFF51AFD7ED558CCD;
    localparam logic [W_WORD-1:0] PERM_MUL_B = 64'hC4CEB9FE1A85EC53;
    localparam logic [W_WORD-1:0] COL_OFFSET = 64'hD1B54A32D192ED03;
    localparam logic [W_WORD-1:0] NNZ_OFFSET = 64'hABC98388FB8FAC03;
    // Offsets folded with the splitmix increment, wrapping at 64 bits.
    localparam logic [W_WORD-1:0] ROW_ADD    = GOLDEN_INC;
    localparam logic [W_WORD-1:0] COL_ADD    = COL_OFFSET + GOLDEN_INC;
    localparam logic [W_WORD-1:0] NNZ_ADD    = NNZ_OFFSET + GOLDEN_INC;

    typedef enum logic [IDX_W-1:0] {
        REG_KEY_HIGH      = 3'd0,
        REG_KEY_LOW       = 3'd1,
        REG_ROW_COUNT     = 3'd2,
        REG_COL_COUNT     = 3'd3,
        REG_NONZERO_COUNT = 3'd4,
        REG_DOMAIN_SIZE   = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_LOAD_MIX,
        ALU_XSH,
        ALU_LOAD_K,
        ALU_XSEED,
        ALU_MUL_P0,
        ALU_MUL_P1,
        ALU_MUL_P2,
        ALU_MUL_P3
    } t_alu_op;

    typedef enum logic [1:0] {
        SEED_KEEP,
        SEED_INIT,
        SEED_XOR
    } t_seed_op;

    typedef enum logic [1:0] {
        MIX_ROW,
        MIX_COL,
        MIX_NNZ
    } t_mix_src;

    typedef enum logic [1:0] {
        MC_SM_A,
        MC_SM_B,
        MC_PERM_A,
        MC_PERM_B
    } t_mul_const;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_OOR,
        COND_SEED_OK,
        COND_GE_DOM
    } t_cond;

    typedef enum logic {
        RES_V,
        RES_DOM
    } t_res_sel;

    typedef struct packed {
        t_alu_op          op;
        t_seed_op         sop;
        t_mix_src         src;
        t_mul_const       mc;
        logic [SH_W-1:0]  sh;
        logic             msk;
        t_cond            cond;
        logic [PC_W-1:0]  tgt;
        logic             done;
        t_res_sel         rsel;
        logic             set_ok;
    } t_ctrl;

    typedef struct packed {
        logic en;       // the current step executes
        logic finish;   // the current step delivers the result item
        logic accept;   // an input item is taken this cycle
    } t_exec;

    typedef struct packed {
        logic oor;          // sample number outside the index range
        logic seed_ok;      // cached seed matches the configuration
        logic ge_dom;       // working value outside the index range
        logic out_blocked;  // output register full and stalled
    } t_stat;

    typedef struct packed {
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] col_count;
        logic [CNT_W-1:0] nonzero_count;
        logic [DOM_W-1:0] domain_size;
        logic [DOM_W-1:0] mask;
    } t_cfg;

    // Program entry points.
    localparam logic [PC_W-1:0] A_SCR  = 6'd41;
    localparam logic [PC_W-1:0] A_LOOP = 6'd42;
    localparam logic [PC_W-1:0] A_ERR  = 6'd55;

    localparam t_ctrl CW_NOP = '{
        op: ALU_NOP, sop: SEED_KEEP, src: MIX_ROW, mc: MC_SM_A, sh: '0,
        msk: 1'b0, cond: COND_NONE, tgt: '0, done: 1'b0, rsel: RES_V,
        set_ok: 1'b0
    };

    function automatic t_ctrl cw_xsh(input logic [SH_W-1:0] sh, input logic msk);
        t_ctrl w;
        w     = CW_NOP;
        w.op  = ALU_XSH;
        w.sh  = sh;
        w.msk = msk;
        return w;
    endfunction

    function automatic t_ctrl cw_mul(input t_alu_op ph, input t_mul_const mc,
                                     input logic msk);
        t_ctrl w;
        w     = CW_NOP;
        w.op  = ph;
        w.mc  = mc;
        w.msk = msk;
        return w;
    endfunction

    function automatic t_ctrl cw_mix(input t_mix_src src, input t_seed_op sop);
        t_ctrl w;
        w     = CW_NOP;
        w.op  = ALU_LOAD_MIX;
        w.src = src;
        w.sop = sop;
        return w;
    endfunction

    // Program layout:
    //   0       range check of the sample number
    //   1       load sample, skip seed build when the cached seed is current
    //   2..14   seed = key, xor mix of row count
    //   15..27  xor mix of column count
    //   28..40  xor mix of nonzero count, mark seed current
    //   41      load sample
    //   42..53  one scramble round
    //   54      walk again while outside the range, else deliver
    //   55      deliver the out-of-range marker
    function automatic t_ctrl ucode_word(input logic [PC_W-1:0] a);
        t_ctrl w;
        w = CW_NOP;
        unique case (a)
            6'd0: begin
                w.cond = COND_OOR;
                w.tgt  = A_ERR;
            end
            6'd1: begin
                w.op   = ALU_LOAD_K;
                w.cond = COND_SEED_OK;
                w.tgt  = A_LOOP;
            end
            6'd2:                 w = cw_mix(MIX_ROW, SEED_INIT);
            6'd15:                w = cw_mix(MIX_COL, SEED_KEEP);
            6'd28:                w = cw_mix(MIX_NNZ, SEED_KEEP);
            6'd3, 6'd16, 6'd29:   w = cw_xsh(6'd30, 1'b0);
            6'd4, 6'd17, 6'd30:   w = cw_mul(ALU_MUL_P0, MC_SM_A, 1'b0);
            6'd5, 6'd18, 6'd31:   w = cw_mul(ALU_MUL_P1, MC_SM_A, 1'b0);
            6'd6, 6'd19, 6'd32:   w = cw_mul(ALU_MUL_P2, MC_SM_A, 1'b0);
            6'd7, 6'd20, 6'd33:   w = cw_mul(ALU_MUL_P3, MC_SM_A, 1'b0);
            6'd8, 6'd21, 6'd34:   w = cw_xsh(6'd27, 1'b0);
            6'd9, 6'd22, 6'd35:   w = cw_mul(ALU_MUL_P0, MC_SM_B, 1'b0);
            6'd10, 6'd23, 6'd36:  w = cw_mul(ALU_MUL_P1, MC_SM_B, 1'b0);
            6'd11, 6'd24, 6'd37:  w = cw_mul(ALU_MUL_P2, MC_SM_B, 1'b0);
            6'd12, 6'd25, 6'd38:  w = cw_mul(ALU_MUL_P3, MC_SM_B, 1'b0);
            6'd13, 6'd26, 6'd39:  w = cw_xsh(6'd31, 1'b0);
            6'd14, 6'd27:         w.sop = SEED_XOR;
            6'd40: begin
                w.sop    = SEED_XOR;
                w.set_ok = 1'b1;
            end
            6'd41:                w.op = ALU_LOAD_K;
            6'd42: begin
                w.op  = ALU_XSEED;
                w.msk = 1'b1;
            end
            6'd43:                w = cw_xsh(6'd33, 1'b0);
            6'd44:                w = cw_mul(ALU_MUL_P0, MC_PERM_A, 1'b0);
            6'd45:                w = cw_mul(ALU_MUL_P1, MC_PERM_A, 1'b0);
            6'd46:                w = cw_mul(ALU_MUL_P2, MC_PERM_A, 1'b0);
            6'd47:                w = cw_mul(ALU_MUL_P3, MC_PERM_A, 1'b1);
            6'd48:                w = cw_xsh(6'd29, 1'b0);
            6'd49:                w = cw_mul(ALU_MUL_P0, MC_PERM_B, 1'b0);
            6'd50:                w = cw_mul(ALU_MUL_P1, MC_PERM_B, 1'b0);
            6'd51:                w = cw_mul(ALU_MUL_P2, MC_PERM_B, 1'b0);
            6'd52:                w = cw_mul(ALU_MUL_P3, MC_PERM_B, 1'b1);
            6'd53:                w = cw_xsh(6'd32, 1'b1);
            6'd54: begin
                w.cond = COND_GE_DOM;
                w.tgt  = A_LOOP;
                w.done = 1'b1;
                w.rsel = RES_V;
            end
            6'd55: begin
                w.done = 1'b1;
                w.rsel = RES_DOM;
            end
            default: w = CW_NOP;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kip_cfg.sv
// ----------------------------------------------------------------------------
// kip_cfg
// Configuration registers with the power-of-two range mask kept alongside
// the range size.
// ----------------------------------------------------------------------------
`default_nettype none

module kip_cfg import kip_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg,
    output logic                   o_seed_dirty
);

    t_cfg              r_cfg;
    logic [DOM_W-1:0]  dom_new;
    logic [DOM_W-1:0]  smear;

    // A zero range size is stored as one. The mask covers every bit up to
    // the highest set bit of size minus one, and is never narrower than one bit.
    always_comb begin
        dom_new = (i_cfg_data[DOM_W-1:0] == '0) ? DOM_W'(1) : i_cfg_data[DOM_W-1:0];
        smear   = dom_new - DOM_W'(1);
        smear   = smear | (smear >> 1);
        smear   = smear | (smear >> 2);
        smear   = smear | (smear >> 4);
        smear   = smear | (smear >> 8);
        smear   = smear | (smear >> 16);
        smear   = smear | (smear >> 32);
        smear   = smear | DOM_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_high      <= '0;
            r_cfg.key_low       <= '0;
            r_cfg.row_count     <= '0;
            r_cfg.col_count     <= '0;
            r_cfg.nonzero_count <= '0;
            r_cfg.domain_size   <= DOM_W'(1);
            r_cfg.mask          <= DOM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_HIGH:      r_cfg.key_high      <= i_cfg_data[KEY_W-1:0];
                REG_KEY_LOW:       r_cfg.key_low       <= i_cfg_data[KEY_W-1:0];
                REG_ROW_COUNT:     r_cfg.row_count     <= i_cfg_data[CNT_W-1:0];
                REG_COL_COUNT:     r_cfg.col_count     <= i_cfg_data[CNT_W-1:0];
                REG_NONZERO_COUNT: r_cfg.nonzero_count <= i_cfg_data[CNT_W-1:0];
                REG_DOMAIN_SIZE: begin
                    r_cfg.domain_size <= dom_new;
                    r_cfg.mask        <= smear;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_seed_dirty = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_HIGH, REG_KEY_LOW, REG_ROW_COUNT, REG_COL_COUNT,
                REG_NONZERO_COUNT: o_seed_dirty = 1'b1;
                default:           o_seed_dirty = 1'b0;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/kip_seq.sv
// ----------------------------------------------------------------------------
// kip_seq
// Microcode sequencer: step counter, program table lookup and conditional
// jumps; takes one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module kip_seq import kip_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  t_stat      i_stat,
    output t_ctrl      o_ctrl,
    output t_exec      o_exec
);

    logic             r_busy;
    logic [PC_W-1:0]  r_pc;
    t_ctrl            cw;
    logic             cond_hit;
    logic             hold;
    t_exec            ex;

    assign cw = ucode_word(r_pc);

    always_comb begin
        unique case (cw.cond)
            COND_NONE:    cond_hit = 1'b0;
            COND_OOR:     cond_hit = i_stat.oor;
            COND_SEED_OK: cond_hit = i_stat.seed_ok;
            COND_GE_DOM:  cond_hit = i_stat.ge_dom;
            default:      cond_hit = 1'b0;
        endcase
    end

    // A delivering step waits while the previous result is still held.
    assign hold      = cw.done && !cond_hit && i_stat.out_blocked;
    assign ex.en     = r_busy && !hold;
    assign ex.finish = r_busy && !hold && cw.done && !cond_hit;
    assign ex.accept = i_in_valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (ex.accept) begin
            r_busy <= 1'b1;
            r_pc   <= '0;
        end else if (ex.en) begin
            if (ex.finish) begin
                r_busy <= 1'b0;
            end
            r_pc <= cond_hit ? cw.tgt : r_pc + PC_W'(1);
        end
    end

    assign o_in_stall = r_busy;
    assign o_ctrl     = cw;
    assign o_exec     = ex;

endmodule

`default_nettype wire

>>> hw/rtl/kip_dp.sv
// ----------------------------------------------------------------------------
// kip_dp
// Datapath: working value, seed cache, one shared 32x32 multiplier with an
// accumulator, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kip_dp import kip_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_cfg                    i_cfg,
    input  wire logic               i_seed_dirty,
    input  t_ctrl                   i_ctrl,
    input  t_exec                   i_exec,
    input  wire logic [SAMP_W-1:0]  i_sample_number,
    input  wire logic               i_out_stall,
    output t_stat                   o_stat,
    output logic                    o_out_valid,
    output logic [DOM_W-1:0]        o_linear_index
);

    logic [SAMP_W-1:0]  r_k;
    logic [W_WORD-1:0]  r_v;
    logic [W_WORD-1:0]  r_seed;
    logic [W_WORD-1:0]  r_acc;
    logic [W_WORD-1:0]  r_prod;
    logic               r_seed_ok;
    logic               r_out_valid;
    logic [DOM_W-1:0]   r_index;

    logic [W_WORD-1:0]  n_v;
    logic [W_WORD-1:0]  mask64;
    logic [W_WORD-1:0]  dom64;
    logic [W_WORD-1:0]  mconst;
    logic [HALF_W-1:0]  mul_a;
    logic [HALF_W-1:0]  mul_b;
    logic [W_WORD-1:0]  mul_p;
    logic [W_WORD-1:0]  mix_src;
    logic [W_WORD-1:0]  mix_add;
    logic [W_WORD-1:0]  prod_hi;

    assign mask64 = {{(W_WORD-DOM_W){1'b0}}, i_cfg.mask};
    assign dom64  = {{(W_WORD-DOM_W){1'b0}}, i_cfg.domain_size};

    always_comb begin
        unique case (i_ctrl.mc)
            MC_SM_A:   mconst = SM_MUL_A;
            MC_SM_B:   mconst = SM_MUL_B;
            MC_PERM_A: mconst = PERM_MUL_A;
            MC_PERM_B: mconst = PERM_MUL_B;
            default:   mconst = SM_MUL_A;
        endcase
    end

    always_comb begin
        unique case (i_ctrl.src)
            MIX_ROW: begin
                mix_src = {{(W_WORD-CNT_W){1'b0}}, i_cfg.row_count};
                mix_add = ROW_ADD;
            end
            MIX_COL: begin
                mix_src = {{(W_WORD-CNT_W){1'b0}}, i_cfg.col_count};
                mix_add = COL_ADD;
            end
            MIX_NNZ: begin
                mix_src = {{(W_WORD-CNT_W){1'b0}}, i_cfg.nonzero_count};
                mix_add = NNZ_ADD;
            end
            default: begin
                mix_src = '0;
                mix_add = ROW_ADD;
            end
        endcase
    end

    // A 64-bit product modulo 2^64 in three partial products: low by low,
    // then the two cross terms, of which only the low halves reach the result.
    assign mul_a   = (i_ctrl.op == ALU_MUL_P2) ? r_v[W_WORD-1:HALF_W] : r_v[HALF_W-1:0];
    assign mul_b   = (i_ctrl.op == ALU_MUL_P1) ? mconst[W_WORD-1:HALF_W] : mconst[HALF_W-1:0];
    assign mul_p   = mul_a * mul_b;
    assign prod_hi = {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};

    always_comb begin
        unique case (i_ctrl.op)
            ALU_NOP:      n_v = r_v;
            ALU_LOAD_MIX: n_v = mix_src + mix_add;
            ALU_XSH:      n_v = r_v ^ (r_v >> i_ctrl.sh);
            ALU_LOAD_K:   n_v = {{(W_WORD-SAMP_W){1'b0}}, r_k};
            ALU_XSEED:    n_v = r_v ^ r_seed;
            ALU_MUL_P0,
            ALU_MUL_P1,
            ALU_MUL_P2:   n_v = r_v;
            ALU_MUL_P3:   n_v = r_acc + prod_hi;
            default:      n_v = r_v;
        endcase
        if (i_ctrl.msk) begin
            n_v = n_v & mask64;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec.accept) begin
            r_k <= i_sample_number;
        end
        if (i_exec.en) begin
            r_v    <= n_v;
            r_prod <= mul_p;
            if (i_ctrl.op == ALU_MUL_P1) begin
                r_acc <= r_prod;
            end else if (i_ctrl.op == ALU_MUL_P2) begin
                r_acc <= r_acc + prod_hi;
            end
            unique case (i_ctrl.sop)
                SEED_KEEP: r_seed <= r_seed;
                SEED_INIT: r_seed <= {i_cfg.key_high, i_cfg.key_low};
                SEED_XOR:  r_seed <= r_seed ^ r_v;
                default:   r_seed <= r_seed;
            endcase
        end
        if (i_exec.finish) begin
            r_index <= (i_ctrl.rsel == RES_DOM) ? i_cfg.domain_size : r_v[DOM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_seed_dirty) begin
                r_seed_ok <= 1'b0;
            end else if (i_exec.en && i_ctrl.set_ok) begin
                r_seed_ok <= 1'b1;
            end
            if (i_exec.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.oor         = {{(DOM_W-SAMP_W){1'b0}}, r_k} >= i_cfg.domain_size;
    assign o_stat.seed_ok     = r_seed_ok;
    assign o_stat.ge_dom      = r_v >= dom64;
    assign o_stat.out_blocked = r_out_valid && i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_linear_index = r_index;

endmodule

`default_nettype wire

>>> hw/rtl/keyed_index_permutation.sv
// An item in range passes the range check and the sample load, then the seed build
// only after a change of a key or count, then walking rounds until it lies in range.
// Each walking round is 13 microcode steps through one shared 32x32 multiplier
// (three partial products per 64-bit multiply).
// An out-of-range sample number goes from the range check to its marker; the next item is taken
// the cycle after a result is written. Synchronous active-low reset.
// ----------------------------------------------------------------------------
// keyed_index_permutation
// Keyed permutation of sample numbers onto a linear index range by cycle
// walking a masked multiply-xorshift bijection.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_index_permutation import kip_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [SAMP_W-1:0]  i_sample_number,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [DOM_W-1:0]        o_linear_index,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    t_cfg   cfg;
    logic   seed_dirty;
    t_ctrl  ctrl;
    t_exec  exec;
    t_stat  stat;

    kip_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg        (cfg),
        .o_seed_dirty (seed_dirty)
    );

    kip_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_exec     (exec)
    );

    kip_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_seed_dirty    (seed_dirty),
        .i_ctrl          (ctrl),
        .i_exec          (exec),
        .i_sample_number (i_sample_number),
        .i_out_stall     (i_out_stall),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_linear_index  (o_linear_index)
    );

endmodule

`default_nettype wire

>>> hw/rtl/kip_checker.sv
// ----------------------------------------------------------------------------
// kip_checker
// Port-level checks of the keyed index permutation block.
// ----------------------------------------------------------------------------
`default_nettype none

module kip_checker import kip_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              o_in_stall,
    input  wire logic              o_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [DOM_W-1:0]  o_linear_index
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item present after reset");

    // An accepted item occupies the block on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after an item was accepted");

    // A new result only comes from an item that was in progress.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item without an item in progress");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_linear_index)))
        else $error("stalled result item changed");

endmodule

bind keyed_index_permutation kip_checker u_kip_checker (.*);

`default_nettype wire
